// ===== src/cseg_pkg.sv =====
`default_nettype none
package cseg_pkg;

  localparam int OP_W    = 2;
  localparam int LEN_W   = 2;
  localparam int VALUE_W = 10;
  localparam int DIGIT_W = 4;
  localparam int WAYS_W  = 30;
  localparam int SEEN_W  = 2;

  localparam int BASE    = 10;
  localparam int ROWS3   = BASE * BASE;
  localparam int ROW3_W  = $clog2(ROWS3);

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_DIGIT = 2'd2;

  localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 2'd3;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [WAYS_W-1:0]  MODULUS   = 30'd1000000007;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [WAYS_W-1:0]  ways_t;
  typedef logic [BASE-1:0]    row_t;

  // quotient by ten for values below 1000, via reciprocal 205 / 2048
  function automatic logic [ROW3_W-1:0] div10(input logic [VALUE_W-1:0] v);
    logic [17:0] p;
    p = {8'b0, v} * 18'd205;
    return p[17:11];
  endfunction

  function automatic digit_t mod10(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] q10;
    q10 = {3'b0, div10(v)} * 10'd10;
    return digit_t'(v - q10);
  endfunction

endpackage
`default_nettype wire

// ===== src/cseg_if.sv =====
`default_nettype none
interface cseg_in_if;
  logic                             valid;
  logic                             ready;
  logic [cseg_pkg::OP_W-1:0]        op;
  logic [cseg_pkg::LEN_W-1:0]       code_length;
  logic [cseg_pkg::VALUE_W-1:0]     code_value;
  logic [cseg_pkg::DIGIT_W-1:0]     digit;
  logic                             first_of_message;

  modport source (
    output valid, op, code_length, code_value, digit, first_of_message,
    input  ready
  );
  modport sink (
    input  valid, op, code_length, code_value, digit, first_of_message,
    output ready
  );
endinterface

interface cseg_out_if;
  logic                         valid;
  logic                         ready;
  logic [cseg_pkg::WAYS_W-1:0]  ways;

  modport source (output valid, ways, input ready);
  modport sink (input valid, ways, output ready);
endinterface
`default_nettype wire

// ===== src/code_segmentation_counter.sv =====
`default_nettype none
// path: a digit word's lookup is registered, then its count is registered onto dout
// throughput: one word per cycle unless dout stalls; the 3-digit code store read is
//   registered, which sets the two-stage depth
// reset: clears the code set (row valid flops, no clearing pass), the look-ahead window
//   and both pipeline stages
module code_segmentation_counter (
  input  wire logic  clk,
  input  wire logic  rst,
  cseg_in_if.sink    din,
  cseg_out_if.source dout
);

  logic accept, is_digit, is_clear, is_add, advance;

  // code set: length one and two in flops, length three in a row memory
  logic [cseg_pkg::BASE-1:0] set1;
  cseg_pkg::row_t            set2 [cseg_pkg::BASE];
  cseg_pkg::row_t            mem3 [cseg_pkg::ROWS3];
  logic [cseg_pkg::ROWS3-1:0] row_vld;

  logic [cseg_pkg::SEEN_W-1:0] digits_seen, seen_eff, seen_next;
  cseg_pkg::digit_t da1, da2;
  cseg_pkg::digit_t d, d_idx, da1_idx, da2_idx;
  logic d_is_code, da1_ok, da2_ok;
  logic sel1_next, sel2_next, cand3_next;
  logic [cseg_pkg::ROW3_W-1:0] row3_rd;

  logic add1, add2, add3;
  logic [cseg_pkg::ROW3_W-1:0] add_row;
  cseg_pkg::digit_t            add_col;
  cseg_pkg::row_t              col_bit, wmask;

  logic p_valid, p_sel1, p_sel2, p_cand3, p_a1, p_a2, p_a3, p_rvld;
  cseg_pkg::digit_t p_col3;
  cseg_pkg::row_t   p_row;

  cseg_pkg::ways_t ways1, ways2, ways3;
  cseg_pkg::ways_t t1, t2, t3, result;
  logic            hit3;
  logic [cseg_pkg::WAYS_W+1:0] sum, m1, m2;

  logic            out_valid;
  cseg_pkg::ways_t out_ways;

  assign advance   = !out_valid || dout.ready;
  assign din.ready = !p_valid || advance;
  assign accept    = din.valid && din.ready;
  assign is_digit  = accept && (din.op == cseg_pkg::OP_DIGIT);
  assign is_clear  = accept && (din.op == cseg_pkg::OP_CLEAR);
  assign is_add    = accept && (din.op == cseg_pkg::OP_ADD);

  // lookup stage
  always_comb begin
    d         = din.digit;
    seen_eff  = din.first_of_message ? '0 : digits_seen;
    seen_next = (seen_eff == cseg_pkg::SEEN_MAX) ? seen_eff : seen_eff + 2'd1;
    d_is_code = (d != '0) && (d <= cseg_pkg::DIGIT_MAX);
    da1_ok    = da1 <= cseg_pkg::DIGIT_MAX;
    da2_ok    = da2 <= cseg_pkg::DIGIT_MAX;
    d_idx     = d_is_code ? d : '0;
    da1_idx   = da1_ok ? da1 : '0;
    da2_idx   = da2_ok ? da2 : '0;
    sel1_next = (d == '0) || (d_is_code && set1[d_idx]);
    sel2_next = d_is_code && (seen_eff >= 2'd1) && da1_ok && set2[d_idx][da1_idx];
    cand3_next = d_is_code && (seen_eff >= 2'd2) && da1_ok && da2_ok;
    row3_rd   = ({3'b0, d_idx} * 7'd10) + {3'b0, da1_idx};
  end

  // code add decode
  always_comb begin
    add1    = (din.code_length == cseg_pkg::LEN_ONE) && (din.code_value < 10'd10);
    add2    = (din.code_length == cseg_pkg::LEN_TWO) && (din.code_value < 10'd100);
    add3    = (din.code_length == cseg_pkg::LEN_THREE) && (din.code_value < 10'd1000);
    add_row = cseg_pkg::div10(din.code_value);
    add_col = cseg_pkg::mod10(din.code_value);
    col_bit = cseg_pkg::row_t'(1) << add_col;
    wmask   = row_vld[add_row] ? col_bit : '1;
  end

  always_ff @(posedge clk) begin
    if (is_add && add3) begin
      for (int b = 0; b < cseg_pkg::BASE; b++) begin
        if (wmask[b]) begin
          mem3[add_row][b] <= col_bit[b];
        end
      end
    end
    if (is_digit) begin
      p_row   <= mem3[row3_rd];
      p_rvld  <= row_vld[row3_rd];
      p_sel1  <= sel1_next;
      p_sel2  <= sel2_next;
      p_cand3 <= cand3_next;
      p_col3  <= da2_idx;
      p_a1    <= seen_eff != '0;
      p_a2    <= seen_eff[1];
      p_a3    <= seen_eff == cseg_pkg::SEEN_MAX;
    end
  end

  // sum stage
  always_comb begin
    hit3   = p_cand3 && p_rvld && p_row[p_col3];
    t1     = p_sel1 ? (p_a1 ? ways1 : cseg_pkg::ways_t'(1)) : '0;
    t2     = p_sel2 ? (p_a2 ? ways2 : cseg_pkg::ways_t'(1)) : '0;
    t3     = hit3 ? (p_a3 ? ways3 : cseg_pkg::ways_t'(1)) : '0;
    sum    = {2'b0, t1} + {2'b0, t2} + {2'b0, t3};
    m1     = {2'b0, cseg_pkg::MODULUS};
    m2     = {1'b0, cseg_pkg::MODULUS, 1'b0};
    if (sum >= m2) begin
      result = cseg_pkg::ways_t'(sum - m2);
    end else if (sum >= m1) begin
      result = cseg_pkg::ways_t'(sum - m1);
    end else begin
      result = sum[cseg_pkg::WAYS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid     <= 1'b0;
      out_valid   <= 1'b0;
      ways1       <= cseg_pkg::ways_t'(1);
      ways2       <= '0;
      ways3       <= '0;
      digits_seen <= '0;
      da1         <= '0;
      da2         <= '0;
      set1        <= '0;
      row_vld     <= '0;
      for (int r = 0; r < cseg_pkg::BASE; r++) begin
        set2[r] <= '0;
      end
    end else begin
      if (din.ready) begin
        p_valid <= is_digit;
      end
      if (advance) begin
        out_valid <= p_valid;
      end
      if (p_valid && advance) begin
        ways3 <= ways2;
        ways2 <= ways1;
        ways1 <= result;
      end
      if (is_digit) begin
        digits_seen <= seen_next;
        da2         <= da1;
        da1         <= d;
      end
      if (is_clear) begin
        set1    <= '0;
        row_vld <= '0;
        for (int r = 0; r < cseg_pkg::BASE; r++) begin
          set2[r] <= '0;
        end
      end else if (is_add) begin
        if (add1) begin
          set1[add_col] <= 1'b1;
        end
        if (add2) begin
          set2[add_row[cseg_pkg::DIGIT_W-1:0]][add_col] <= 1'b1;
        end
        if (add3) begin
          row_vld[add_row] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && advance) begin
      out_ways <= result;
    end
  end

  assign dout.valid = out_valid;
  assign dout.ways  = out_ways;

endmodule
`default_nettype wire
